// ----- rtl/scma_pkg.sv -----
// ----------------------------------------------------------------------------
// scma_pkg
// Types and constants shared by the sparse COO matrix accumulator.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int IDX_W   = 8;
  localparam int VAL_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 1'd1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        entry_row;
    logic [IDX_W-1:0]        entry_col;
    logic signed [VAL_W-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    logic                    empty_res;
    logic                    dropped;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_SRD,
    ST_SCMP,
    ST_INS,
    ST_UPR,
    ST_UPW,
    ST_PUT,
    ST_DNR,
    ST_DNW,
    ST_DRN,
    ST_DLST
  } state_t;

endpackage

// ----- rtl/sparse_coo_matrix_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_coo_matrix_accumulator_unit
// Sorted table of nonzero sparse-matrix entries with insert and drain.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low. An insert
// first scales and range-checks the value, then reads and compares the stored
// entries in order; a new entry is then written after the entries above its
// place are shifted up, an entry is dropped on a full table, and a sum that
// returns to zero removes the entry by shifting the later entries down. The
// single read port of the entry table makes search and shifts go entry by entry.
// A drain of N entries issues one result per cycle, each registered after its
// table read; busy falls as the last one is presented; an empty drain gives
// one result the cycle after start. Results appear for exactly one cycle
// with strobe high and cannot be held off. Configuration writes are always
// ready and are meant for when busy is low.
// ----------------------------------------------------------------------------
module sparse_coo_matrix_accumulator_unit
  import scma_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int MATRIX_DIM  = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cmd_t                 cmd,
  output logic                 busy,
  output result_t              result,
  output logic                 strobe,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [VAL_W-1:0] scale;
  logic             transpose_on;
  logic             mul_load;
  logic [VAL_W-1:0] prod;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= VAL_W'(1);
      transpose_on <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE:     scale <= cfg_data;
        REG_TRANSPOSE: transpose_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  scma_scale u_scale (
    .clk   (clk),
    .load  (mul_load),
    .value (cmd.entry_value),
    .scale (scale),
    .prod  (prod)
  );

  scma_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  scma_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MATRIX_DIM  (MATRIX_DIM),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .transpose_on (transpose_on),
    .mul_load     (mul_load),
    .prod         (prod),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .result       (result),
    .strobe       (strobe)
  );

endmodule

// ----- rtl/scma_mem.sv -----
// ----------------------------------------------------------------------------
// scma_mem
// Entry table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scma_mem
  import scma_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/scma_scale.sv -----
// ----------------------------------------------------------------------------
// scma_scale
// Registered 32x32 multiply of the incoming value by the scale, low word kept.
// ----------------------------------------------------------------------------
module scma_scale
  import scma_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [VAL_W-1:0] value,
  input  logic [VAL_W-1:0] scale,
  output logic [VAL_W-1:0] prod
);

  logic [VAL_W-1:0] op_a;
  logic [VAL_W-1:0] op_b;

  always_ff @(posedge clk) begin
    if (load) begin
      op_a <= value;
      op_b <= scale;
    end
    prod <= op_a * op_b;
  end

endmodule

// ----- rtl/scma_ctrl.sv -----
// ----------------------------------------------------------------------------
// scma_ctrl
// Sequencer: sorted search, shift up/down and drain over the entry table.
// ----------------------------------------------------------------------------
module scma_ctrl
  import scma_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int MATRIX_DIM  = 256,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cmd_t             cmd,
  output logic             busy,
  input  logic             transpose_on,
  output logic             mul_load,
  input  logic [VAL_W-1:0] prod,
  output logic [AW-1:0]    rd_addr,
  input  entry_t           rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output entry_t           wr_data,
  output result_t          result,
  output logic             strobe
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [IDX_W:0] DIM    = (IDX_W+1)'(MATRIX_DIM);

  state_t           state, state_next;
  logic [CW-1:0]    count;
  logic             dropped_flag;
  logic [CW-1:0]    ptr;
  logic [CW-1:0]    mv;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_r;
  logic             pend;
  logic             pend_last;

  logic [CW-1:0]    ptr_inc;
  logic [CW-1:0]    mv_dec;
  logic [2*IDX_W-1:0] key_new;
  logic [2*IDX_W-1:0] key_mem;
  logic [VAL_W-1:0] sum;
  logic             out_range;
  logic             empty_drain;

  assign ptr_inc     = ptr + CW'(1);
  assign mv_dec      = mv - CW'(1);
  assign key_new     = {row_r, col_r};
  assign key_mem     = {rd_data.row, rd_data.col};
  assign sum         = rd_data.value + prod;
  assign out_range   = ({1'b0, row_r} >= DIM) || ({1'b0, col_r} >= DIM);
  assign empty_drain = (state == ST_IDLE) && start && (cmd.func == FUNC_DRAIN) &&
                       (count == '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.func == FUNC_DRAIN) begin
            state_next = (count == '0) ? ST_IDLE : ST_DRN;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: state_next = ST_CHK;
      ST_CHK: begin
        if (prod == '0 || out_range) begin
          state_next = ST_IDLE;
        end else if (count == '0) begin
          state_next = ST_INS;
        end else begin
          state_next = ST_SRD;
        end
      end
      ST_SRD: state_next = ST_SCMP;
      ST_SCMP: begin
        if (key_mem < key_new) begin
          state_next = (ptr_inc == count) ? ST_INS : ST_SRD;
        end else if (key_mem == key_new) begin
          state_next = (sum == '0) ? ST_DNR : ST_IDLE;
        end else begin
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        if (count == MAX_CNT) begin
          state_next = ST_IDLE;
        end else if (mv == ptr) begin
          state_next = ST_PUT;
        end else begin
          state_next = ST_UPR;
        end
      end
      ST_UPR: state_next = ST_UPW;
      ST_UPW: state_next = (mv_dec == ptr) ? ST_PUT : ST_UPR;
      ST_PUT: state_next = ST_IDLE;
      ST_DNR: state_next = (ptr_inc >= count) ? ST_IDLE : ST_DNW;
      ST_DNW: state_next = ST_DNR;
      ST_DRN: state_next = (ptr_inc == count) ? ST_DLST : ST_DRN;
      ST_DLST: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != ST_IDLE);
    mul_load = (state == ST_IDLE) && start;
    rd_addr  = ptr[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = ptr[AW-1:0];
    wr_data  = rd_data;
    case (state)
      ST_SCMP: begin
        if (key_mem == key_new && sum != '0) begin
          wr_en   = 1'b1;
          wr_data = '{row: row_r, col: col_r, value: sum};
        end
      end
      ST_UPR: rd_addr = mv_dec[AW-1:0];
      ST_UPW: begin
        wr_en   = 1'b1;
        wr_addr = mv[AW-1:0];
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_data = '{row: row_r, col: col_r, value: prod};
      end
      ST_DNR: rd_addr = ptr_inc[AW-1:0];
      ST_DNW: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      dropped_flag <= 1'b0;
      strobe       <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= pend || empty_drain;
      pend   <= (state == ST_DRN);
      if (pend) begin
        result.out_row   <= rd_data.row;
        result.out_col   <= rd_data.col;
        result.out_value <= rd_data.value;
        result.last      <= pend_last;
        result.empty_res <= 1'b0;
        result.dropped   <= dropped_flag;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            ptr   <= '0;
            row_r <= transpose_on ? cmd.entry_col : cmd.entry_row;
            col_r <= transpose_on ? cmd.entry_row : cmd.entry_col;
            if (cmd.func == FUNC_DRAIN && count == '0) begin
              result.out_row   <= '0;
              result.out_col   <= '0;
              result.out_value <= '0;
              result.last      <= 1'b1;
              result.empty_res <= 1'b1;
              result.dropped   <= dropped_flag;
              dropped_flag     <= 1'b0;
            end
          end
        end
        ST_CHK: begin
          ptr <= '0;
          mv  <= count;
        end
        ST_SCMP: begin
          mv <= count;
          if (key_mem < key_new) begin
            ptr <= ptr_inc;
          end
        end
        ST_INS: begin
          if (count == MAX_CNT) begin
            dropped_flag <= 1'b1;
          end
        end
        ST_UPW: mv <= mv_dec;
        ST_PUT: count <= count + CW'(1);
        ST_DNR: begin
          if (ptr_inc >= count) begin
            count <= count - CW'(1);
          end
        end
        ST_DNW: ptr <= ptr_inc;
        ST_DRN: begin
          pend_last <= (ptr_inc == count);
          ptr       <= ptr_inc;
        end
        ST_DLST: begin
          count        <= '0;
          dropped_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
